/* src/pas_pkg.sv */
package pas_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAX_DEPTH = 16;

	localparam int LIN_QBITS  = 34;
	localparam int SQRT_STEPS = 32;
	localparam int LOG_BITS   = 30;
	localparam int OUT_QBITS  = MAX_DEPTH + 1;

	localparam logic [25:0] LN2_Q26 = 26'd46516320;

	localparam int LIN_LAT = 4 + LIN_QBITS;
	localparam int ASH_LAT = 6 + SQRT_STEPS + LOG_BITS;
	localparam int OUT_LAT = 4 + OUT_QBITS;
	localparam int LATENCY = LIN_LAT + 2 * ASH_LAT + OUT_LAT;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALED_BG   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALED_PEAK = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLACK       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WHITE       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BITS  = 3'd6;

	typedef struct packed {
		logic signed [31:0] background_level;
		logic signed [31:0] scaled_background;
		logic signed [31:0] peak_level;
		logic signed [31:0] scaled_peak;
		logic signed [31:0] black_level;
		logic signed [31:0] white_level;
		logic [4:0]         pixel_bits;
	} cfg_t;

	function automatic logic [32:0] mag33(input logic signed [32:0] v);
		return v[32] ? 33'(-v) : 33'(v);
	endfunction

endpackage

/* src/pas_linmap.sv */
module pas_linmap (
	input  logic                clk,
	input  logic                arst_n,
	input  pas_pkg::cfg_t       cfg,
	input  logic                in_valid,
	input  logic signed [31:0]  x,
	output logic                out_valid,
	output logic signed [31:0]  m
);
	localparam int QB = pas_pkg::LIN_QBITS;
	localparam int RW = 33 + QB;
	localparam logic [QB-1:0] QMAX = QB'(1) << 33;

	logic signed [32:0] sr, dx, rg;
	logic [32:0]        sr_mag_s1, dx_mag_s1, rg_mag_q;
	logic               neg_s1, vld_s1;
	logic [65:0]        prod_s2;
	logic               neg_s2, vld_s2;
	logic [RW-1:0]      rem_s [0:QB];
	logic [QB-1:0]      quo_s [0:QB];
	logic               neg_s [0:QB];
	logic               sat_s [0:QB];
	logic               vld_s [0:QB];
	logic [QB-1:0]      q;
	logic signed [QB+1:0] sum;
	logic signed [31:0] m_n, m_s;
	logic               vld_o;

	assign sr = 33'(cfg.scaled_peak) - 33'(cfg.scaled_background);
	assign dx = 33'(x) - 33'(cfg.background_level);
	assign rg = 33'(cfg.peak_level) - 33'(cfg.background_level);

	always_ff @(posedge clk) begin
		rg_mag_q  <= pas_pkg::mag33(rg);
		sr_mag_s1 <= pas_pkg::mag33(sr);
		dx_mag_s1 <= pas_pkg::mag33(dx);
		neg_s1    <= sr[32] ^ dx[32] ^ rg[32];
		prod_s2   <= 66'(sr_mag_s1) * 66'(dx_mag_s1);
		neg_s2    <= neg_s1;
		rem_s[0]  <= RW'(prod_s2);
		quo_s[0]  <= '0;
		neg_s[0]  <= neg_s2;
		sat_s[0]  <= RW'(prod_s2) >= (RW'(rg_mag_q) << QB);
	end

	for (genvar i = 0; i < QB; i++) begin : g_div
		logic [RW-1:0] cand;
		assign cand = RW'(rg_mag_q) << (QB - 1 - i);
		always_ff @(posedge clk) begin
			if (rem_s[i] >= cand) begin
				rem_s[i+1] <= rem_s[i] - cand;
				quo_s[i+1] <= {quo_s[i][QB-2:0], 1'b1};
			end else begin
				rem_s[i+1] <= rem_s[i];
				quo_s[i+1] <= {quo_s[i][QB-2:0], 1'b0};
			end
			neg_s[i+1] <= neg_s[i];
			sat_s[i+1] <= sat_s[i];
		end
	end

	always_comb begin
		if (sat_s[QB] || quo_s[QB] > QMAX) begin
			q = QMAX;
		end else begin
			q = quo_s[QB];
		end
		if (neg_s[QB]) begin
			sum = (QB+2)'(cfg.scaled_background) - $signed({2'b00, q});
		end else begin
			sum = (QB+2)'(cfg.scaled_background) + $signed({2'b00, q});
		end
		if (sum[QB+1:31] == {(QB-29){sum[31]}}) begin
			m_n = sum[31:0];
		end else if (sum[QB+1]) begin
			m_n = 32'sh8000_0000;
		end else begin
			m_n = 32'sh7FFF_FFFF;
		end
	end

	always_ff @(posedge clk) begin
		m_s <= m_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			for (int j = 0; j <= QB; j++) begin
				vld_s[j] <= 1'b0;
			end
			vld_o <= 1'b0;
		end else begin
			vld_s1   <= in_valid;
			vld_s2   <= vld_s1;
			vld_s[0] <= vld_s2;
			for (int j = 0; j < QB; j++) begin
				vld_s[j+1] <= vld_s[j];
			end
			vld_o <= vld_s[QB];
		end
	end

	assign out_valid = vld_o;
	assign m         = m_s;

endmodule

/* src/pas_asinh.sv */
module pas_asinh (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic signed [31:0]  y,
	output logic                out_valid,
	output logic signed [31:0]  res
);
	localparam int SQ = pas_pkg::SQRT_STEPS;
	localparam int LB = pas_pkg::LOG_BITS;
	localparam int F  = pas_pkg::FRAC_BITS;

	logic [31:0]  a_s1;
	logic         neg_s1, vld_s1;
	logic [62:0]  sv_s [0:SQ];
	logic [62:0]  sr_s [0:SQ];
	logic [31:0]  sa_s [0:SQ];
	logic         sn_s [0:SQ];
	logic         sq_vld_s [0:SQ];
	logic [33:0]  t_n, t_st;
	logic [5:0]   k_n, k_st;
	logic         neg_st, vld_st;
	logic [30:0]  z_n;
	logic [30:0]  zq_s [0:LB];
	logic [LB-1:0] fr_s [0:LB];
	logic [5:0]   kk_s [0:LB];
	logic         ln_s [0:LB];
	logic         lg_vld_s [0:LB];
	logic [31:0]  phi_sp;
	logic [55:0]  plo_sp;
	logic         neg_sp, vld_sp;
	logic [63:0]  p_n;
	logic [31:0]  r_n;
	logic signed [31:0] res_so;
	logic         vld_so;

	always_ff @(posedge clk) begin
		a_s1     <= y[31] ? 32'(-y) : 32'(y);
		neg_s1   <= y[31];
		sv_s[0]  <= 63'(64'(a_s1) * 64'(a_s1)) + (63'(1) << (2 * F));
		sr_s[0]  <= '0;
		sa_s[0]  <= a_s1;
		sn_s[0]  <= neg_s1;
	end

	for (genvar i = 0; i < SQ; i++) begin : g_sqrt
		localparam logic [62:0] BIT = 63'(1) << (62 - 2 * i);
		logic [63:0] rb;
		assign rb = {1'b0, sr_s[i]} + {1'b0, BIT};
		always_ff @(posedge clk) begin
			if ({1'b0, sv_s[i]} >= rb) begin
				sv_s[i+1] <= sv_s[i] - rb[62:0];
				sr_s[i+1] <= (sr_s[i] >> 1) + BIT;
			end else begin
				sv_s[i+1] <= sv_s[i];
				sr_s[i+1] <= sr_s[i] >> 1;
			end
			sa_s[i+1] <= sa_s[i];
			sn_s[i+1] <= sn_s[i];
		end
	end

	always_comb begin
		t_n = {2'b00, sa_s[SQ]} + sr_s[SQ][33:0];
		k_n = '0;
		for (int j = 0; j < 34; j++) begin
			if (t_n[j]) begin
				k_n = 6'(j);
			end
		end
	end

	always_comb begin
		if (k_st <= 6'd30) begin
			z_n = 31'({30'b0, t_st} << (6'd30 - k_st));
		end else begin
			z_n = 31'(t_st >> (k_st - 6'd30));
		end
	end

	always_ff @(posedge clk) begin
		t_st     <= t_n;
		k_st     <= k_n;
		neg_st   <= sn_s[SQ];
		zq_s[0]  <= z_n;
		fr_s[0]  <= '0;
		kk_s[0]  <= k_st;
		ln_s[0]  <= neg_st;
	end

	for (genvar i = 0; i < LB; i++) begin : g_log
		logic [63:0] pr;
		assign pr = (64'(zq_s[i]) * 64'(zq_s[i])) >> 30;
		always_ff @(posedge clk) begin
			if (pr[31]) begin
				zq_s[i+1] <= pr[31:1];
				fr_s[i+1] <= {fr_s[i][LB-2:0], 1'b1};
			end else begin
				zq_s[i+1] <= pr[30:0];
				fr_s[i+1] <= {fr_s[i][LB-2:0], 1'b0};
			end
			kk_s[i+1] <= kk_s[i];
			ln_s[i+1] <= ln_s[i];
		end
	end

	always_comb begin
		p_n = (64'(phi_sp) << 30) + 64'(plo_sp) + (64'(1) << (55 - F));
		r_n = 32'(p_n >> (56 - F));
	end

	always_ff @(posedge clk) begin
		phi_sp <= 32'((32'(kk_s[LB]) - 32'(F)) * 32'(pas_pkg::LN2_Q26));
		plo_sp <= 56'(fr_s[LB]) * 56'(pas_pkg::LN2_Q26);
		neg_sp <= ln_s[LB];
		res_so <= neg_sp ? -$signed(r_n) : $signed(r_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int j = 0; j <= SQ; j++) begin
				sq_vld_s[j] <= 1'b0;
			end
			vld_st <= 1'b0;
			for (int j = 0; j <= LB; j++) begin
				lg_vld_s[j] <= 1'b0;
			end
			vld_sp <= 1'b0;
			vld_so <= 1'b0;
		end else begin
			vld_s1      <= in_valid;
			sq_vld_s[0] <= vld_s1;
			for (int j = 0; j < SQ; j++) begin
				sq_vld_s[j+1] <= sq_vld_s[j];
			end
			vld_st      <= sq_vld_s[SQ];
			lg_vld_s[0] <= vld_st;
			for (int j = 0; j < LB; j++) begin
				lg_vld_s[j+1] <= lg_vld_s[j];
			end
			vld_sp <= lg_vld_s[LB];
			vld_so <= vld_sp;
		end
	end

	assign out_valid = vld_so;
	assign res       = res_so;

endmodule

/* src/pas_outmap.sv */
module pas_outmap (
	input  logic                clk,
	input  logic                arst_n,
	input  pas_pkg::cfg_t       cfg,
	input  logic                in_valid,
	input  logic signed [31:0]  u,
	output logic                out_valid,
	output logic [15:0]         pixel,
	output logic                bad_setup
);
	localparam int QB = pas_pkg::OUT_QBITS;
	localparam int NW = 52;

	localparam logic [1:0] CLS_ZERO = 2'd0;
	localparam logic [1:0] CLS_FULL = 2'd1;
	localparam logic [1:0] CLS_MID  = 2'd2;

	logic signed [33:0] w_n, d_n;
	logic               wneg_q, bad_q;
	logic [32:0]        wmag_q;
	logic [15:0]        full_q;
	logic [4:0]         depth;
	logic signed [33:0] d_s1;
	logic               vld_s1, vld_s2;
	logic [1:0]         cls_s2;
	logic [48:0]        prod_s2;
	logic [NW-1:0]      rem_s [0:QB];
	logic [QB-1:0]      quo_s [0:QB];
	logic [1:0]         cls_s [0:QB];
	logic               vld_s [0:QB];
	logic [15:0]        pix_n, pix_so;
	logic               bad_so, vld_so;

	assign w_n   = 34'(cfg.white_level) - 34'(cfg.black_level);
	assign depth = (cfg.pixel_bits > 5'(pas_pkg::MAX_DEPTH)) ? 5'(pas_pkg::MAX_DEPTH)
	               : cfg.pixel_bits;
	assign d_n   = 34'(u) - 34'(cfg.black_level);

	always_ff @(posedge clk) begin
		wneg_q <= w_n[33];
		wmag_q <= w_n[33] ? 33'(-w_n) : 33'(w_n);
		full_q <= 16'((17'(1) << depth) - 17'(1));
		bad_q  <= (w_n == '0) || (cfg.peak_level == cfg.background_level);
	end

	always_ff @(posedge clk) begin
		d_s1 <= wneg_q ? -d_n : d_n;
		if (d_s1 <= 34'sd0) begin
			cls_s2 <= CLS_ZERO;
		end else if (d_s1 >= $signed({1'b0, wmag_q})) begin
			cls_s2 <= CLS_FULL;
		end else begin
			cls_s2 <= CLS_MID;
		end
		prod_s2  <= 49'(d_s1[32:0]) * 49'(full_q);
		rem_s[0] <= NW'({prod_s2, 1'b0}) + NW'(wmag_q);
		quo_s[0] <= '0;
		cls_s[0] <= cls_s2;
	end

	for (genvar i = 0; i < QB; i++) begin : g_div
		logic [NW-1:0] cand;
		assign cand = NW'({wmag_q, 1'b0}) << (QB - 1 - i);
		always_ff @(posedge clk) begin
			if (rem_s[i] >= cand) begin
				rem_s[i+1] <= rem_s[i] - cand;
				quo_s[i+1] <= {quo_s[i][QB-2:0], 1'b1};
			end else begin
				rem_s[i+1] <= rem_s[i];
				quo_s[i+1] <= {quo_s[i][QB-2:0], 1'b0};
			end
			cls_s[i+1] <= cls_s[i];
		end
	end

	always_comb begin
		case (cls_s[QB])
			CLS_ZERO: pix_n = '0;
			CLS_FULL: pix_n = full_q;
			CLS_MID:  pix_n = quo_s[QB][15:0];
			default:  pix_n = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			for (int j = 0; j <= QB; j++) begin
				vld_s[j] <= 1'b0;
			end
			vld_so <= 1'b0;
			pix_so <= '0;
			bad_so <= 1'b0;
		end else begin
			vld_s1   <= in_valid;
			vld_s2   <= vld_s1;
			vld_s[0] <= vld_s2;
			for (int j = 0; j < QB; j++) begin
				vld_s[j+1] <= vld_s[j];
			end
			vld_so <= vld_s[QB];
			if (vld_s[QB]) begin
				pix_so <= bad_q ? 16'd0 : pix_n;
				bad_so <= bad_q;
			end else begin
				pix_so <= '0;
				bad_so <= 1'b0;
			end
		end
	end

	assign out_valid = vld_so;
	assign pixel     = pix_so;
	assign bad_setup = bad_so;

endmodule

/* src/pixel_asinh_stretch.sv */
// Channel    Handshake          Payload
// request    start (busy = 0)   sample[31:0]
// result     done               pixel[15:0], bad_setup
// config     cfg_we             cfg_addr[2:0], cfg_wdata[31:0]
//
// A request may be issued every clock cycle; busy is never raised.
// Each result follows its request through the two division pipelines and the
// square root and logarithm stages, and results come out in request order.
// The result strobe done is high for one cycle and the receiver cannot stall.
// arst_n clears all valid bits and loads the register reset values.
module pixel_asinh_stretch (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [31:0]                sample,
	output logic                              done,
	output logic [15:0]                       pixel,
	output logic                              bad_setup,
	input  logic                              cfg_we,
	input  logic [pas_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [31:0]                       cfg_wdata
);
	pas_pkg::cfg_t      cfg_q;
	logic               req;
	logic               lin_vld, a1_vld, a2_vld;
	logic signed [31:0] lin_m, a1_res, a2_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.background_level  <= 32'sd0;
			cfg_q.scaled_background <= 32'sd0;
			cfg_q.peak_level        <= 32'sd65536;
			cfg_q.scaled_peak       <= 32'sd65536;
			cfg_q.black_level       <= 32'sd0;
			cfg_q.white_level       <= 32'sd65536;
			cfg_q.pixel_bits        <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_addr)
				pas_pkg::REG_BACKGROUND:  cfg_q.background_level  <= cfg_wdata;
				pas_pkg::REG_SCALED_BG:   cfg_q.scaled_background <= cfg_wdata;
				pas_pkg::REG_PEAK:        cfg_q.peak_level        <= cfg_wdata;
				pas_pkg::REG_SCALED_PEAK: cfg_q.scaled_peak       <= cfg_wdata;
				pas_pkg::REG_BLACK:       cfg_q.black_level       <= cfg_wdata;
				pas_pkg::REG_WHITE:       cfg_q.white_level       <= cfg_wdata;
				pas_pkg::REG_PIXEL_BITS:  cfg_q.pixel_bits        <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;
	assign req  = start && !busy;

	pas_linmap u_lin (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (req),
		.x         (sample),
		.out_valid (lin_vld),
		.m         (lin_m)
	);

	pas_asinh u_ash1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (lin_vld),
		.y         (lin_m),
		.out_valid (a1_vld),
		.res       (a1_res)
	);

	pas_asinh u_ash2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (a1_vld),
		.y         (a1_res),
		.out_valid (a2_vld),
		.res       (a2_res)
	);

	pas_outmap u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (a2_vld),
		.u         (a2_res),
		.out_valid (done),
		.pixel     (pixel),
		.bad_setup (bad_setup)
	);

endmodule

/* src/pas_checker.sv */
module pas_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [15:0] pixel,
	input logic        bad_setup
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, pas_pkg::LATENCY))
		else $error("result without matching request");

	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> (pixel == 16'd0 && !bad_setup))
		else $error("result ports not quiet between results");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && bad_setup) |-> pixel == 16'd0)
		else $error("nonzero pixel with bad setup");

endmodule

bind pixel_asinh_stretch pas_checker u_pas_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.pixel     (pixel),
	.bad_setup (bad_setup)
);

/* sim/pixel_asinh_stretch_test.sv */
module pixel_asinh_stretch_test;

	localparam logic [pas_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 13;
	localparam int PHASE_ITEMS = 100;

	typedef struct {
		logic [15:0] pixel;
		logic        bad;
	} pixel_t;

	typedef enum {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [2:0]         addr;
		logic signed [31:0] value;
		bit                 typed;
		logic [15:0]        pixel;
		logic               bad;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] sample;
	logic               done;
	logic [15:0]        pixel;
	logic               bad_setup;
	logic               cfg_we;
	logic [2:0]         cfg_addr;
	logic [31:0]        cfg_wdata;

	pas_pkg::cfg_t stretch_cfg;
	pixel_t        pending_pixels[$];
	int            errors = 0;
	int            cycles = 0;
	bit            no_gaps = 0;

	pixel_asinh_stretch i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sample(sample),
		.done(done), .pixel(pixel), .bad_setup(bad_setup),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint fixed_asinh(longint y);
		longint unsigned a, t, z, frac, lg, res;
		int k;
		a = magnitude(y);
		t = a + int_sqrt(a * a + (64'd1 << (2 * pas_pkg::FRAC_BITS)));
		k = 0;
		while (k < 63 && (t >> (k + 1)) != 0)
			k++;
		z = (k <= 30) ? (t << (30 - k)) : (t >> (k - 30));
		frac = 0;
		for (int i = 0; i < 30; i++) begin
			z = (z * z) >> 30;
			frac <<= 1;
			if (z >= (64'd1 << 31)) begin
				z >>= 1;
				frac |= 1;
			end
		end
		lg = (longint'(k - pas_pkg::FRAC_BITS) << 30) | frac;
		res = (lg * longint'(pas_pkg::LN2_Q26) + (64'd1 << (55 - pas_pkg::FRAC_BITS)))
			>> (56 - pas_pkg::FRAC_BITS);
		return y < 0 ? -longint'(res) : longint'(res);
	endfunction

	function automatic pixel_t stretch_pixel(logic signed [31:0] s);
		pixel_t r;
		longint x, sr, dx, rg, w, m, u, d, bg, sb;
		longint unsigned q, full;
		int depth;
		bit neg;
		x = s;
		bg = stretch_cfg.background_level;
		sb = stretch_cfg.scaled_background;
		sr = longint'(stretch_cfg.scaled_peak) - sb;
		dx = x - bg;
		rg = longint'(stretch_cfg.peak_level) - bg;
		w = longint'(stretch_cfg.white_level) - longint'(stretch_cfg.black_level);
		if (rg == 0 || w == 0) begin
			r.pixel = 0;
			r.bad = 1;
			return r;
		end
		q = (magnitude(sr) * magnitude(dx)) / magnitude(rg);
		if (q > (64'd1 << 33))
			q = 64'd1 << 33;
		neg = ((sr < 0) != (dx < 0)) != (rg < 0);
		m = sb + (neg ? -longint'(q) : longint'(q));
		if (m > 64'sh7FFFFFFF)
			m = 64'sh7FFFFFFF;
		if (m < -64'sh80000000)
			m = -64'sh80000000;
		u = fixed_asinh(fixed_asinh(m));
		depth = stretch_cfg.pixel_bits > pas_pkg::MAX_DEPTH ? pas_pkg::MAX_DEPTH
			: stretch_cfg.pixel_bits;
		full = (64'd1 << depth) - 1;
		d = u - longint'(stretch_cfg.black_level);
		if (w < 0) begin
			w = -w;
			d = -d;
		end
		if (d <= 0)
			r.pixel = 0;
		else if (d >= w)
			r.pixel = full[15:0];
		else
			r.pixel = 16'((2 * longint'(d) * full + w) / (2 * w));
		r.bad = 0;
		return r;
	endfunction

	task automatic drain();
		start = 0;
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] value);
		cfg_we = 1;
		cfg_addr = addr;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 0;
		case (addr)
			pas_pkg::REG_BACKGROUND:  stretch_cfg.background_level = value;
			pas_pkg::REG_SCALED_BG:   stretch_cfg.scaled_background = value;
			pas_pkg::REG_PEAK:        stretch_cfg.peak_level = value;
			pas_pkg::REG_SCALED_PEAK: stretch_cfg.scaled_peak = value;
			pas_pkg::REG_BLACK:       stretch_cfg.black_level = value;
			pas_pkg::REG_WHITE:       stretch_cfg.white_level = value;
			pas_pkg::REG_PIXEL_BITS:  stretch_cfg.pixel_bits = value[4:0];
			default: ;
		endcase
	endtask

	task automatic load_setup(logic [31:0] bg, logic [31:0] sb, logic [31:0] pk,
			logic [31:0] sp, logic [31:0] blk, logic [31:0] wht, logic [31:0] depth);
		drain();
		write_reg(pas_pkg::REG_BACKGROUND, bg);
		write_reg(pas_pkg::REG_SCALED_BG, sb);
		write_reg(pas_pkg::REG_PEAK, pk);
		write_reg(pas_pkg::REG_SCALED_PEAK, sp);
		write_reg(pas_pkg::REG_BLACK, blk);
		write_reg(pas_pkg::REG_WHITE, wht);
		write_reg(pas_pkg::REG_PIXEL_BITS, depth);
	endtask

	task automatic send_request(logic signed [31:0] s, bit typed, pixel_t typed_pixel);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			start = 0;
			repeat (gap) @(negedge clk);
		end
		start = 1;
		sample = s;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_pixels.push_back(typed ? typed_pixel : stretch_pixel(s));
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected result: pixel %0d bad_setup %0b", pixel, bad_setup);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				if (pixel !== want.pixel) begin
					$error("pixel: expected %0d, got %0d", want.pixel, pixel);
					errors++;
				end
				if (bad_setup !== want.bad) begin
					$error("bad_setup: expected %0b, got %0b", want.bad, bad_setup);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	row_t directed[] = '{
		'{ROW_SAMPLE, 0, 32'sd0, 1, 16'd0, 1'b0},
		'{ROW_SAMPLE, 0, 32'sh7FFFFFFF, 1, 16'd65535, 1'b0},
		'{ROW_SAMPLE, 0, -32'sh80000000, 1, 16'd0, 1'b0},
		'{ROW_SAMPLE, 0, 32'sd65536, 0, 0, 0},
		'{ROW_SAMPLE, 0, 32'sd1, 0, 0, 0},
		'{ROW_SAMPLE, 0, 32'sd32768, 0, 0, 0},
		'{ROW_SAMPLE, 0, -32'sd65536, 1, 16'd0, 1'b0},
		'{ROW_SAMPLE, 0, 32'sd200000, 0, 0, 0},
		'{ROW_WRITE, pas_pkg::REG_PEAK, 32'sd0, 0, 0, 0},
		'{ROW_SAMPLE, 0, 32'sd65536, 1, 16'd0, 1'b1},
		'{ROW_SAMPLE, 0, -32'sh80000000, 1, 16'd0, 1'b1},
		'{ROW_WRITE, pas_pkg::REG_PEAK, 32'sd65536, 0, 0, 0},
		'{ROW_WRITE, pas_pkg::REG_WHITE, 32'sd0, 0, 0, 0},
		'{ROW_SAMPLE, 0, 32'sd100000, 1, 16'd0, 1'b1},
		'{ROW_WRITE, pas_pkg::REG_WHITE, 32'sd65536, 0, 0, 0},
		'{ROW_WRITE, pas_pkg::REG_PIXEL_BITS, 32'sd0, 0, 0, 0},
		'{ROW_SAMPLE, 0, 32'sh7FFFFFFF, 1, 16'd0, 1'b0},
		'{ROW_WRITE, pas_pkg::REG_PIXEL_BITS, 32'sd31, 0, 0, 0},
		'{ROW_SAMPLE, 0, 32'sd40000, 0, 0, 0},
		'{ROW_WRITE, pas_pkg::REG_PIXEL_BITS, 32'sd1, 0, 0, 0},
		'{ROW_SAMPLE, 0, 32'sd40000, 0, 0, 0},
		'{ROW_WRITE, REG_UNUSED, 32'shFFFFFFFF, 0, 0, 0},
		'{ROW_SAMPLE, 0, 32'sd150000, 0, 0, 0},
		'{ROW_WRITE, pas_pkg::REG_SCALED_PEAK, 32'sh7FFFFFFF, 0, 0, 0},
		'{ROW_WRITE, pas_pkg::REG_PEAK, 32'sd1, 0, 0, 0},
		'{ROW_SAMPLE, 0, 32'sh7FFFFFFF, 0, 0, 0},
		'{ROW_SAMPLE, 0, -32'sh80000000, 0, 0, 0}
	};

	initial begin
		pixel_t typed_pixel;
		longint bg, pk, sb, sp, blk, wht, x;
		logic signed [31:0] s;
		start = 0;
		sample = 0;
		cfg_we = 0;
		cfg_addr = 0;
		cfg_wdata = 0;
		stretch_cfg = '{0, 0, 65536, 65536, 0, 65536, 5'd16};
		arst_n = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_WRITE) begin
				drain();
				write_reg(directed[i].addr, directed[i].value);
			end else begin
				typed_pixel.pixel = directed[i].pixel;
				typed_pixel.bad = directed[i].bad;
				send_request(directed[i].value, directed[i].typed, typed_pixel);
			end
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: load_setup(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
						32'h80000000, 32'h7FFFFFFF, 31);
				1: load_setup(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
						32'h7FFFFFFF, 32'h80000000, 1);
				2: load_setup(0, 0, 1, 32'h7FFFFFFF, -200000, 200000, 16);
				default: begin
					bg = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
					pk = bg + ($urandom_range(0, 1) ? 1 : -1)
						* longint'($urandom_range(1, 1 << 24));
					sb = longint'($urandom_range(0, 8 << 16)) - (4 << 16);
					sp = sb + ($urandom_range(0, 1) ? 1 : -1)
						* longint'($urandom_range(1, 64 << 16));
					blk = longint'($urandom_range(0, 300000)) - 150000;
					wht = blk + ($urandom_range(0, 3) != 0 ? 1 : -1)
						* longint'($urandom_range(1, 250000));
					load_setup(32'(bg), 32'(sb), 32'(pk), 32'(sp), 32'(blk), 32'(wht),
						$urandom_range(0, 31));
				end
			endcase
			no_gaps = (p % 4 == 3);
			bg = stretch_cfg.background_level;
			pk = stretch_cfg.peak_level;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 5 && n == PHASE_ITEMS / 2)
					drain();
				if (p < 3 || $urandom_range(0, 9) < 3) begin
					s = $urandom;
				end else begin
					x = bg + (longint'($urandom_range(0, 1200)) - 100) * (pk - bg) / 1000;
					s = 32'(x);
				end
				send_request(s, 0, typed_pixel);
			end
		end

		drain();
		repeat (pas_pkg::LATENCY + 20) @(negedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* filelist.f */
src/pas_pkg.sv
src/pas_linmap.sv
src/pas_asinh.sv
src/pas_outmap.sv
src/pixel_asinh_stretch.sv
src/pas_checker.sv
sim/pixel_asinh_stretch_test.sv
